FILE: rtl/first_fit_block_allocator_core_macros.svh
// Assertion macros for the first-fit block allocator.
// Used by first_fit_block_allocator_core.sv; no other dependencies.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");
// next-cycle implication
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");
`else
`define FFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ffba_pkg.sv
// Shared widths, codes and reset values of the first-fit block allocator.
// No dependencies.
`default_nettype none

package ffba_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int OFF_W        = 12;
	localparam int CNT_W        = 13;
	localparam int ACT_W        = 2;
	localparam int STAT_W       = 2;
	localparam int BCAP_W       = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_W        = 13;

	localparam logic [CNT_W-1:0]  RST_CHR_VCAP = 13'd500;
	localparam logic [BCAP_W-1:0] RST_CHR_BCAP = 8'd20;
	localparam logic [CNT_W-1:0]  RST_OBJ_VCAP = 13'd1500;
	localparam logic [BCAP_W-1:0] RST_OBJ_BCAP = 8'd40;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_INIT  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOFIT    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_ALREADY  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHR_VCAP = 2'd0,
		CFG_CHR_BCAP = 2'd1,
		CFG_OBJ_VCAP = 2'd2,
		CFG_OBJ_BCAP = 2'd3
	} cfg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/first_fit_block_allocator_core.sv
// First-fit block allocator with coalescing over two pools; descriptors in one RAM.
// Depends on ffba_pkg and first_fit_block_allocator_core_macros.svh.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  request  | req_valid/req_ready, action, pool,        | in
//           | request_count, release_offset             |
//  response | rsp_valid/rsp_ready, status, alloc_offset,| out
//           | free_vertices                             |
//  config   | cfg_write_en, cfg_index, cfg_wdata        | in
//
// One beat at a time. Each list node visited takes a check state and a wait state
// (descriptor RAM read); an allocate that splits scans the slots for an unused
// descriptor and writes the remainder; a free may merge with either neighbour after
// the walk; a split or merge may add a back-link fix-up. Initialise writes both pool heads.
// Reset clears the slot-in-use flags at once: no RAM clearing pass.
// A response waiting on rsp_ready does not hold off the next request beat.
`default_nettype none
`include "first_fit_block_allocator_core_macros.svh"

module first_fit_block_allocator_core #(
	parameter int MAX_BLOCKS = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [ffba_pkg::ACT_W-1:0]     action,
	input  logic                           pool,
	input  logic [ffba_pkg::CNT_W-1:0]     request_count,
	input  logic [ffba_pkg::OFF_W-1:0]     release_offset,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [ffba_pkg::STAT_W-1:0]    status,
	output logic [ffba_pkg::OFF_W-1:0]     alloc_offset,
	output logic [ffba_pkg::CNT_W-1:0]     free_vertices,
	input  logic                           cfg_write_en,
	input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffba_pkg::CFG_W-1:0]     cfg_wdata
);
	import ffba_pkg::*;

	localparam int SW    = $clog2(MAX_BLOCKS);
	localparam int LW    = SW + 1;
	localparam int AW    = SW + 1;
	localparam int DEPTH = 2 ** AW;
	localparam logic [LW-1:0] NO_LINK = '1;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [CNT_W-1:0] size;
		logic             alloc;
		logic [LW-1:0]    next;
		logic [LW-1:0]    prev;
	} desc_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT0, S_INIT1, S_A_CHK, S_A_WAIT, S_A_SCAN, S_A_WRJ,
		S_F_CHK, S_F_WAIT, S_F_NXT, S_F_PRV0, S_F_PRV, S_FIX_RD, S_FIX_WR, S_DONE
	} state_t;

	function automatic logic [AW-1:0] slot_idx(input logic p, input logic [LW-1:0] s);
		return {p, s[SW-1:0]};
	endfunction

	function automatic logic [CNT_W-1:0] take_fn(input logic [CNT_W-1:0] c,
			input logic [CNT_W-1:0] n);
		return (c >= n) ? c - n : '0;
	endfunction

	function automatic logic [CNT_W-1:0] give_fn(input logic [CNT_W-1:0] c,
			input logic [CNT_W-1:0] n);
		logic [CNT_W:0] t;
		t = {1'b0, c} + {1'b0, n};
		return (t > (CNT_W+1)'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : t[CNT_W-1:0];
	endfunction

	// configuration and live pool settings
	logic [CNT_W-1:0]  cfg_vcap_q [2];
	logic [BCAP_W-1:0] cfg_bcap_q [2];
	logic [CNT_W-1:0]  vcap_q [2];
	logic [LW-1:0]     bcap_q [2];
	logic [CNT_W-1:0]  free_q [2];
	logic [CNT_W-1:0]  sat_vcap [2];
	logic [LW-1:0]     sat_bcap [2];
	logic              used_q [DEPTH];

	// request and walk registers
	state_t           st_q, ret_q;
	logic             pool_q;
	logic [CNT_W-1:0] req_q;
	logic [OFF_W-1:0] off_q;
	logic [LW-1:0]    cur_q, n_q, u_q, fix_addr_q, fix_val_q;
	desc_t            rec_q;
	status_t          stat_q;
	logic [OFF_W-1:0] offs_q;

	// response registers
	logic             rsp_valid_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [OFF_W-1:0] rsp_offset_q;
	logic [CNT_W-1:0] rsp_free_q;

	// descriptor RAM
	desc_t           mem [DEPTH];
	desc_t           rd_data_q;
	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	desc_t           mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_data_q <= mem[mem_raddr];
	end

	// saturated capacities taken on initialise
	always_comb begin
		for (int p = 0; p < 2; p++) begin
			sat_vcap[p] = (cfg_vcap_q[p] > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
				: cfg_vcap_q[p];
			if (cfg_bcap_q[p] == '0)
				sat_bcap[p] = LW'(1);
			else if (int'(cfg_bcap_q[p]) > MAX_BLOCKS)
				sat_bcap[p] = LW'(MAX_BLOCKS);
			else
				sat_bcap[p] = LW'(cfg_bcap_q[p]);
		end
	end

	// shared decode of the current step
	logic [LW-1:0]    cap;
	logic [CNT_W-1:0] free_cur;
	logic [AW-1:0]    cur_idx, u_idx, nx_idx, pv_idx, fix_idx;
	logic             walk_ok, a_fit, f_hit, f_own, scan_ok, scan_free, nx_merge, pv_merge;

	assign cap       = bcap_q[pool_q];
	assign free_cur  = free_q[pool_q];
	assign cur_idx   = slot_idx(pool_q, cur_q);
	assign u_idx     = slot_idx(pool_q, u_q);
	assign nx_idx    = slot_idx(pool_q, rec_q.next);
	assign pv_idx    = slot_idx(pool_q, rec_q.prev);
	assign fix_idx   = slot_idx(pool_q, fix_addr_q);
	assign walk_ok   = (n_q < cap) && (cur_q < cap);
	assign a_fit     = used_q[cur_idx] && !rd_data_q.alloc && (rd_data_q.size >= req_q);
	assign f_hit     = (rd_data_q.start == off_q);
	assign f_own     = used_q[cur_idx] && rd_data_q.alloc;
	assign scan_ok   = (u_q < cap);
	assign scan_free = !used_q[u_idx];
	assign nx_merge  = used_q[nx_idx] && !rd_data_q.alloc;
	assign pv_merge  = used_q[pv_idx] && !rd_data_q.alloc;

	// RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = cur_idx;
		mem_raddr = cur_idx;
		mem_wdata = rec_q;
		unique case (st_q)
			S_INIT0, S_INIT1: begin
				mem_we          = 1'b1;
				mem_waddr       = slot_idx(st_q == S_INIT1, '0);
				mem_wdata.start = '0;
				mem_wdata.size  = vcap_q[st_q == S_INIT1];
				mem_wdata.alloc = 1'b0;
				mem_wdata.next  = NO_LINK;
				mem_wdata.prev  = NO_LINK;
			end
			S_A_CHK, S_F_CHK: begin
				mem_re = walk_ok;
			end
			S_A_WAIT: begin
				mem_we          = a_fit && (rd_data_q.size == req_q);
				mem_wdata       = rd_data_q;
				mem_wdata.alloc = 1'b1;
			end
			S_A_SCAN: begin
				mem_we          = !scan_ok || scan_free;
				mem_wdata.alloc = 1'b1;
				if (scan_ok) begin
					mem_wdata.size = req_q;
					mem_wdata.next = u_q;
				end
			end
			S_A_WRJ: begin
				mem_we          = 1'b1;
				mem_waddr       = u_idx;
				mem_wdata.start = rec_q.start + req_q[OFF_W-1:0];
				mem_wdata.size  = rec_q.size - req_q;
				mem_wdata.alloc = 1'b0;
				mem_wdata.next  = rec_q.next;
				mem_wdata.prev  = cur_q;
			end
			S_F_WAIT: begin
				mem_re    = f_hit && f_own && (rd_data_q.next < cap);
				mem_raddr = slot_idx(pool_q, rd_data_q.next);
			end
			S_F_PRV0: begin
				mem_we    = 1'b1;
				mem_re    = (rec_q.prev < cap);
				mem_raddr = pv_idx;
			end
			S_F_PRV: begin
				mem_we         = pv_merge;
				mem_waddr      = pv_idx;
				mem_wdata      = rd_data_q;
				mem_wdata.size = rd_data_q.size + rec_q.size;
				mem_wdata.next = rec_q.next;
			end
			S_FIX_RD: begin
				mem_re    = 1'b1;
				mem_raddr = fix_idx;
			end
			S_FIX_WR: begin
				mem_we         = 1'b1;
				mem_waddr      = fix_idx;
				mem_wdata      = rd_data_q;
				mem_wdata.prev = fix_val_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer, configuration and response registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= S_IDLE;
			ret_q         <= S_DONE;
			rsp_valid_q   <= 1'b0;
			cfg_vcap_q[0] <= RST_CHR_VCAP;
			cfg_bcap_q[0] <= RST_CHR_BCAP;
			cfg_vcap_q[1] <= RST_OBJ_VCAP;
			cfg_bcap_q[1] <= RST_OBJ_BCAP;
			vcap_q        <= '{default: '0};
			bcap_q        <= '{default: '0};
			free_q        <= '{default: '0};
			used_q        <= '{default: 1'b0};
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_CHR_VCAP: cfg_vcap_q[0] <= cfg_wdata;
					CFG_CHR_BCAP: cfg_bcap_q[0] <= cfg_wdata[BCAP_W-1:0];
					CFG_OBJ_VCAP: cfg_vcap_q[1] <= cfg_wdata;
					CFG_OBJ_BCAP: cfg_bcap_q[1] <= cfg_wdata[BCAP_W-1:0];
				endcase
			end
			// a new response beat in S_DONE takes over the handshake
			if (rsp_valid_q && rsp_ready && (st_q != S_DONE))
				rsp_valid_q <= 1'b0;

			unique case (st_q)
				S_IDLE: begin
					if (req_valid) begin
						pool_q <= pool;
						req_q  <= request_count;
						off_q  <= release_offset;
						stat_q <= ST_OK;
						offs_q <= '0;
						cur_q  <= '0;
						n_q    <= '0;
						case (action_t'(action))
							ACT_ALLOC: st_q <= S_A_CHK;
							ACT_FREE: begin
								if ({1'b0, release_offset} >= vcap_q[pool]) begin
									stat_q <= ST_NOTFOUND;
									st_q   <= S_DONE;
								end else begin
									st_q <= S_F_CHK;
								end
							end
							ACT_INIT: begin
								vcap_q <= sat_vcap;
								bcap_q <= sat_bcap;
								free_q <= sat_vcap;
								// only slot 0 of each pool in use
								for (int i = 0; i < DEPTH; i++)
									used_q[i] <= (AW'(i) == slot_idx(1'b0, '0)) ||
										(AW'(i) == slot_idx(1'b1, '0));
								st_q <= S_INIT0;
							end
							default: st_q <= S_DONE;
						endcase
					end
				end
				S_INIT0: st_q <= S_INIT1;
				S_INIT1: st_q <= S_DONE;
				// allocate: first-fit walk
				S_A_CHK: begin
					if (walk_ok) begin
						st_q <= S_A_WAIT;
					end else begin
						stat_q <= ST_NOFIT;
						st_q   <= S_DONE;
					end
				end
				S_A_WAIT: begin
					if (a_fit) begin
						rec_q <= rd_data_q;
						if (rd_data_q.size != req_q) begin
							u_q  <= '0;
							st_q <= S_A_SCAN;
						end else begin
							free_q[pool_q] <= take_fn(free_cur, rd_data_q.size);
							offs_q         <= rd_data_q.start;
							st_q           <= S_DONE;
						end
					end else begin
						cur_q <= rd_data_q.next;
						n_q   <= n_q + LW'(1);
						st_q  <= S_A_CHK;
					end
				end
				// look for the lowest unused slot to split into
				S_A_SCAN: begin
					if (!scan_ok) begin
						free_q[pool_q] <= take_fn(free_cur, rec_q.size);
						offs_q         <= rec_q.start;
						st_q           <= S_DONE;
					end else if (scan_free) begin
						used_q[u_idx]  <= 1'b1;
						free_q[pool_q] <= take_fn(free_cur, req_q);
						offs_q         <= rec_q.start;
						st_q           <= S_A_WRJ;
					end else begin
						u_q <= u_q + LW'(1);
					end
				end
				S_A_WRJ: begin
					if (rec_q.next < cap) begin
						fix_addr_q <= rec_q.next;
						fix_val_q  <= u_q;
						ret_q      <= S_DONE;
						st_q       <= S_FIX_RD;
					end else begin
						st_q <= S_DONE;
					end
				end
				// free: walk by start offset
				S_F_CHK: begin
					if (walk_ok) begin
						st_q <= S_F_WAIT;
					end else begin
						stat_q <= ST_NOTFOUND;
						st_q   <= S_DONE;
					end
				end
				S_F_WAIT: begin
					if (f_hit) begin
						if (!f_own) begin
							stat_q <= ST_ALREADY;
							st_q   <= S_DONE;
						end else begin
							rec_q          <= {rd_data_q.start, rd_data_q.size, 1'b0,
								rd_data_q.next, rd_data_q.prev};
							free_q[pool_q] <= give_fn(free_cur, rd_data_q.size);
							st_q <= (rd_data_q.next < cap) ? S_F_NXT : S_F_PRV0;
						end
					end else begin
						cur_q <= rd_data_q.next;
						n_q   <= n_q + LW'(1);
						st_q  <= S_F_CHK;
					end
				end
				// merge with a free next neighbour
				S_F_NXT: begin
					st_q <= S_F_PRV0;
					if (nx_merge) begin
						rec_q          <= {rec_q.start, rec_q.size + rd_data_q.size,
							rec_q.alloc, rd_data_q.next, rec_q.prev};
						used_q[nx_idx] <= 1'b0;
						if (rd_data_q.next < cap) begin
							fix_addr_q <= rd_data_q.next;
							fix_val_q  <= cur_q;
							ret_q      <= S_F_PRV0;
							st_q       <= S_FIX_RD;
						end
					end
				end
				S_F_PRV0: st_q <= (rec_q.prev < cap) ? S_F_PRV : S_DONE;
				// merge into a free previous neighbour
				S_F_PRV: begin
					st_q <= S_DONE;
					if (pv_merge) begin
						used_q[cur_idx] <= 1'b0;
						if (rec_q.next < cap) begin
							fix_addr_q <= rec_q.next;
							fix_val_q  <= rec_q.prev;
							ret_q      <= S_DONE;
							st_q       <= S_FIX_RD;
						end
					end
				end
				// back-link fix-up, read then write
				S_FIX_RD: st_q <= S_FIX_WR;
				S_FIX_WR: st_q <= ret_q;
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= stat_q;
						rsp_offset_q <= offs_q;
						rsp_free_q   <= free_q[pool_q];
						st_q         <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready     = (st_q == S_IDLE);
	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign alloc_offset  = rsp_offset_q;
	assign free_vertices = rsp_free_q;

	// checks
	`FFBA_ASSERT_IMP(a_free_bound, clk, arst_n, 1'b1,
		(free_q[0] <= CNT_W'(MAX_VERTICES)) && (free_q[1] <= CNT_W'(MAX_VERTICES)))
	`FFBA_ASSERT_IMP(a_no_rw_clash, clk, arst_n, mem_we && mem_re, mem_waddr != mem_raddr)
	`FFBA_ASSERT_IMP(a_split_slot_used, clk, arst_n, st_q == S_A_WRJ, used_q[u_idx])
	`FFBA_ASSERT_NXT(a_fix_writes_back, clk, arst_n, st_q == S_FIX_RD,
		mem_we && (mem_waddr == $past(mem_raddr)))

endmodule

`default_nettype wire
